@@ rtl/core/sset_pkg.sv @@
// ----------------------------------------------------------------------------
// sset_pkg
// Shared types and codes for the sparse set direct table: command and
// response beats, operation codes and status codes.
// ----------------------------------------------------------------------------
package sset_pkg;

    // Field widths of the command and response beats
    localparam int KEY_W    = 10;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;

    // Operation codes; the unused code behaves as a search
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
    } rsp_t;

endpackage

@@ rtl/core/sparse_set_direct_table.sv @@
// ----------------------------------------------------------------------------
// sparse_set_direct_table
// Sparse set over a direct-address slot table that is never cleared. A key's
// slot is trusted only when it points below the entry count at a stack entry
// holding that key. Search, insert and delete one key per command beat.
//
//   channel   ports                  direction  handshake
//   command   start, busy, cmd       in         taken when start && !busy
//   response  done, rsp              out        one-cycle strobe, no stall
//
// Sequencing: insert responds from the lookup state; search and a missed
// delete respond from the check state; a hit delete does too, or from the
// fix state when the moved top key needs its slot repointed. The slot memory's
// single write port and registered read, then the dependent stack read, set these steps.
// Reset clears only the entry count and control; neither memory is swept,
// so commands are taken from the first cycle after reset.
// The response strobe is issued as the block returns to idle; the receiver
// must take it in that cycle.
// ----------------------------------------------------------------------------
module sparse_set_direct_table
    import sset_pkg::*;
#(
    parameter int KEY_SPACE   = 1024,
    parameter int STACK_DEPTH = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    localparam int KW = $clog2(KEY_SPACE);
    localparam int PW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_CHECK = 4'b0100,
        S_FIX   = 4'b1000
    } state_t;

    // Fold a command key into the key space by shifted compare and subtract
    function automatic logic [KW-1:0] reduce_key(input logic [KEY_W-1:0] k);
        logic [KEY_W:0] r;
        r = {1'b0, k};
        for (int i = KEY_W - 1; i >= 0; i--)
        begin
            if (longint'(r) >= (longint'(KEY_SPACE) << i))
            begin
                r = r - (KEY_W + 1)'(longint'(KEY_SPACE) << i);
            end
        end
        return KW'(r);
    endfunction

    // Memories
    logic [PW-1:0] slot_mem  [KEY_SPACE];
    logic [KW-1:0] stack_mem [STACK_DEPTH];

    // Control and datapath registers
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [FUNC_W-1:0] func_reg;
    logic [KW-1:0]     key_reg;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [KW-1:0]     moved_reg, moved_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    // Memory ports
    logic [KW-1:0] slot_raddr;
    logic [PW-1:0] slot_rdata_reg;
    logic          slot_we;
    logic [KW-1:0] slot_waddr;
    logic [PW-1:0] slot_wdata;
    logic [PW-1:0] stack_raddr_a, stack_raddr_b;
    logic [KW-1:0] stack_rdata_a_reg, stack_rdata_b_reg;
    logic          stack_we;
    logic [PW-1:0] stack_waddr;
    logic [KW-1:0] stack_wdata;

    logic          accept;
    logic          is_full;
    logic          hit;
    logic [PW-1:0] top;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign rsp     = rsp_reg;
    assign is_full = (count_reg >= CW'(STACK_DEPTH));
    assign top     = PW'(count_reg - 1'b1);
    assign hit     = (CW'(pos_reg) < count_reg) && (stack_rdata_a_reg == key_reg);

    // Read the slot at the incoming key; stack at the slot and at the top
    assign slot_raddr    = reduce_key(cmd.key);
    assign stack_raddr_a = slot_rdata_reg;
    assign stack_raddr_b = top;

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    // Stack memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rdata_a_reg <= stack_mem[stack_raddr_a];
        stack_rdata_b_reg <= stack_mem[stack_raddr_b];
    end

    // Sequence one command through lookup, check and fix-up
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        moved_next  = moved_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        slot_we     = 1'b0;
        slot_waddr  = key_reg;
        slot_wdata  = top;
        stack_we    = 1'b0;
        stack_waddr = pos_reg;
        stack_wdata = stack_rdata_b_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                pos_next = slot_rdata_reg;
                if (func_reg == FUNC_INSERT)
                begin
                    // Push the key and point its slot at the new top
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (is_full)
                    begin
                        rsp_next = '{status: ST_FULL, position: '0};
                    end
                    else
                    begin
                        stack_we    = 1'b1;
                        stack_waddr = count_reg[PW-1:0];
                        stack_wdata = key_reg;
                        slot_we     = 1'b1;
                        slot_waddr  = key_reg;
                        slot_wdata  = count_reg[PW-1:0];
                        count_next  = count_reg + 1'b1;
                        rsp_next    = '{status: ST_OK,
                                        position: POS_W'(count_reg[PW-1:0])};
                    end
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                // Anything but a confirmed slot counts as a miss
                if (hit && (func_reg != FUNC_DELETE))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{status: ST_OK, position: POS_W'(pos_reg)};
                end
                else if (hit)
                begin
                    // Drop the key: its slot takes the freed top position
                    slot_we    = 1'b1;
                    slot_waddr = key_reg;
                    slot_wdata = top;
                    count_next = count_reg - 1'b1;
                    moved_next = stack_rdata_b_reg;
                    rsp_next   = '{status: ST_OK, position: POS_W'(pos_reg)};
                    if (pos_reg != top)
                    begin
                        // Move the top key into the hole
                        stack_we    = 1'b1;
                        stack_waddr = pos_reg;
                        stack_wdata = stack_rdata_b_reg;
                    end
                    if ((pos_reg != top) && (stack_rdata_b_reg != key_reg))
                    begin
                        state_next = S_FIX;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{status: ST_ABSENT, position: '0};
                end
            end

            S_FIX:
            begin
                // Repoint the moved key's slot
                slot_we    = 1'b1;
                slot_waddr = moved_reg;
                slot_wdata = pos_reg;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= cmd.func;
            key_reg  <= reduce_key(cmd.key);
        end
        pos_reg   <= pos_next;
        moved_reg <= moved_next;
        rsp_reg   <= rsp_next;
    end

    // Checks
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("response without a command in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count above stack depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == ST_OK) && (func_reg == FUNC_INSERT))
            |-> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("insert did not grow the stack by one");

    a_fail_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_OK)) |-> (rsp.position == '0))
        else $error("failed response carries a position");

endmodule

@@ tb/sset_shadow_pkg.sv @@
// ----------------------------------------------------------------------------
// sset_shadow_pkg
// Shadow copy of the sparse set for the testbench. Each accepted command beat
// updates the shadow slot table, key stack and fill, and queues the response
// it must produce. Each response beat is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
package sset_shadow_pkg;

    import sset_pkg::*;

    localparam int KEY_SPACE   = 1024;
    localparam int STACK_DEPTH = 256;

    class sset_shadow;

        logic [POS_W-1:0] slot_of [KEY_SPACE];
        logic [KEY_W-1:0] keys_at [STACK_DEPTH];
        int unsigned      fill;
        rsp_t             expected_rsp [$];
        int unsigned      mismatches;

        function new();
            foreach (slot_of[i])
                slot_of[i] = '0;
            foreach (keys_at[i])
                keys_at[i] = '0;
            fill       = 0;
            mismatches = 0;
        endfunction

        // Print one line per mismatch (capped) and count every one
        task report(string what);
            if (mismatches < 100)
                $display("tb mismatch: %s", what);
            mismatches++;
        endtask

        // Apply one accepted command to the shadow set and queue its response
        function void apply_command(cmd_t c);
            rsp_t             r;
            int unsigned      p;
            int unsigned      top;
            logic [KEY_W-1:0] moved;
            bit               hit;
            r.status   = ST_ABSENT;
            r.position = '0;
            p          = slot_of[c.key];
            hit        = (p < fill) && (keys_at[p] == c.key);
            case (c.func)
                FUNC_INSERT:
                begin
                    if (fill >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                    end
                    else begin
                        keys_at[fill]  = c.key;
                        slot_of[c.key] = POS_W'(fill);
                        r.status       = ST_OK;
                        r.position     = POS_W'(fill);
                        fill++;
                    end
                end
                FUNC_DELETE:
                begin
                    if (hit) begin
                        top = fill - 1;
                        // Move the top key into the freed position
                        if (p != top) begin
                            moved          = keys_at[top];
                            keys_at[p]     = moved;
                            slot_of[moved] = POS_W'(p);
                        end
                        // Point the deleted slot at the freed top
                        slot_of[c.key] = POS_W'(top);
                        fill           = top;
                        r.status       = ST_OK;
                        r.position     = POS_W'(p);
                    end
                end
                default:
                begin
                    // Search, and the unused code acting as a search
                    if (hit) begin
                        r.status   = ST_OK;
                        r.position = POS_W'(p);
                    end
                end
            endcase
            expected_rsp.push_back(r);
        endfunction

        // Compare one response beat with the oldest pending one
        task check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0) begin
                report($sformatf("unexpected response: status %0d position %0d",
                                 got.status, got.position));
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.position !== want.position)
                report($sformatf("position got %0d want %0d",
                                 got.position, want.position));
        endtask

    endclass

endpackage

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sparse_set_direct_table. A short directed sequence covers the
// key extremes, every operation, the unused code, duplicate inserts, stale
// slots after delete and absent deletes. Random traffic then fills the stack
// to full, drains it to empty and mixes operations, with random idle gaps on
// the command side. Responses are checked against a shadow set.
// ----------------------------------------------------------------------------
module tb_top
    import sset_pkg::*, sset_shadow_pkg::*;
();

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1100;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} traffic_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    sset_shadow shadow = new();
    bit         idle_enable = 1'b1;

    sparse_set_direct_table #(
        .KEY_SPACE   (KEY_SPACE),
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    // Free-running clock, period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Check every response beat
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_response(rsp);
    end

    function automatic cmd_t make_beat(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k);
        cmd_t c;
        c.func = f;
        c.key  = k;
        return c;
    endfunction

    // Pick a key: from the live set, an extreme, a small pool or anywhere
    function automatic logic [KEY_W-1:0] pick_key(bit from_set);
        int unsigned r;
        r = $urandom_range(99);
        if (from_set && shadow.fill != 0)
            return shadow.keys_at[$urandom_range(shadow.fill - 1)];
        if (r < 5)
            return {KEY_W{1'b0}};
        if (r < 10)
            return {KEY_W{1'b1}};
        if (r < 45)
            return KEY_W'($urandom_range(63));
        return KEY_W'($urandom);
    endfunction

    // Drive one command beat, with an optional idle gap, until accepted
    task automatic send_beat(cmd_t c);
        int unsigned gap;
        gap = 0;
        if (idle_enable && $urandom_range(99) < 32)
            gap = ($urandom_range(9) == 0) ? $urandom_range(12, 3) : $urandom_range(2, 1);
        repeat (gap)
        begin
            start <= 1'b0;
            cmd   <= {FUNC_W'($urandom), KEY_W'($urandom)};
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        shadow.apply_command(c);
    endtask

    task automatic run_directed();
        // Empty set: search, delete, unused code
        send_beat(make_beat(FUNC_SEARCH, 10'd0));
        send_beat(make_beat(FUNC_DELETE, 10'd1023));
        send_beat(make_beat(FUNC_UNUSED, 10'd5));
        // Extremes, then a duplicate insert
        send_beat(make_beat(FUNC_INSERT, 10'd0));
        send_beat(make_beat(FUNC_INSERT, 10'd1023));
        send_beat(make_beat(FUNC_SEARCH, 10'd0));
        send_beat(make_beat(FUNC_SEARCH, 10'd1023));
        send_beat(make_beat(FUNC_INSERT, 10'd0));
        send_beat(make_beat(FUNC_SEARCH, 10'd0));
        // Delete the top entry; its slot goes stale
        send_beat(make_beat(FUNC_DELETE, 10'd0));
        send_beat(make_beat(FUNC_SEARCH, 10'd0));
        // Alternating bit patterns, then delete from the middle
        send_beat(make_beat(FUNC_INSERT, 10'h2AA));
        send_beat(make_beat(FUNC_INSERT, 10'h155));
        send_beat(make_beat(FUNC_DELETE, 10'd1023));
        send_beat(make_beat(FUNC_SEARCH, 10'h155));
        send_beat(make_beat(FUNC_SEARCH, 10'd1023));
        send_beat(make_beat(FUNC_DELETE, 10'd1023));
        send_beat(make_beat(FUNC_UNUSED, 10'h155));
        send_beat(make_beat(FUNC_SEARCH, 10'h2AA));
        send_beat(make_beat(FUNC_DELETE, 10'd0));
        send_beat(make_beat(FUNC_SEARCH, 10'd0));
    endtask

    task automatic run_random();
        traffic_mode_t    mode;
        int unsigned      roll;
        int unsigned      ins_pct;
        int unsigned      del_pct;
        int unsigned      full_seen;
        int unsigned      mix_left;
        logic [FUNC_W-1:0] f;
        logic [KEY_W-1:0]  k;
        mode      = MODE_GROW;
        full_seen = 0;
        mix_left  = 0;
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Hold a long stretch with no idling
            idle_enable = (i < 400) || (i >= 600);
            case (mode)
                MODE_GROW:   begin ins_pct = 70; del_pct = 12; end
                MODE_SHRINK: begin ins_pct = 10; del_pct = 70; end
                default:     begin ins_pct = 33; del_pct = 30; end
            endcase
            roll = $urandom_range(99);
            if (roll < 5)
                f = FUNC_UNUSED;
            else if (roll < 5 + ins_pct)
                f = FUNC_INSERT;
            else if (roll < 5 + ins_pct + del_pct)
                f = FUNC_DELETE;
            else
                f = FUNC_SEARCH;
            if (f == FUNC_INSERT)
                k = pick_key($urandom_range(99) < 20);
            else
                k = pick_key($urandom_range(99) < 75);
            send_beat(make_beat(f, k));
            // Advance the traffic mode: fill to full, drain to empty, mix
            case (mode)
                MODE_GROW:
                begin
                    if (shadow.fill == STACK_DEPTH)
                        full_seen++;
                    if (full_seen >= 12) begin
                        full_seen = 0;
                        mode      = MODE_SHRINK;
                    end
                end
                MODE_SHRINK:
                begin
                    if (shadow.fill == 0) begin
                        mix_left = 150;
                        mode     = MODE_MIX;
                    end
                end
                default:
                begin
                    mix_left--;
                    if (mix_left == 0)
                        mode = MODE_GROW;
                end
            endcase
        end
    endtask

    initial
    begin
        int unsigned waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        start <= 1'b0;
        // Wait for every pending response, then allow for the latency
        waited = 0;
        while (shadow.expected_rsp.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        while (shadow.expected_rsp.size() != 0)
        begin
            shadow.report("response never arrived");
            void'(shadow.expected_rsp.pop_front());
        end
        if (shadow.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // End a hung run
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
